### rtl/core/itoa_pkg.sv
// Shared types, constants and helpers for the radix-to-ASCII converter.
package itoa_pkg;

    // Field widths fixed by the interface
    localparam int NUMBER_FIELD_W = 16;
    localparam int RADIX_FIELD_W  = 5;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;

    // Default converted width and divider bits retired per cycle
    localparam int NUMBER_WIDTH_DEF = 16;
    localparam int BITS_PER_STEP    = 4;

    // Legal base range
    localparam logic [RADIX_FIELD_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_FIELD_W-1:0] RADIX_MAX = 5'd16;

    // ASCII anchors
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [DIGIT_W-1:0] DECIMAL_TEN  = 4'd10;

    typedef struct packed {
        logic [NUMBER_FIELD_W-1:0] number;
        logic [RADIX_FIELD_W-1:0]  radix;
    } req_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } chr_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic pop;
    } itoa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic quot_zero;
        logic out_free;
        logic last_digit;
    } itoa_status_t;

    // Map a digit value 0..15 to its upper-case ASCII character
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DECIMAL_TEN)
            g = ASCII_ZERO + CHAR_W'(d);
        else
            g = ASCII_UPPER_A + CHAR_W'(d - DECIMAL_TEN);
        return g;
    endfunction

endpackage

### rtl/core/integer_to_radix_ascii.sv
// Top level of the unsigned integer to radix-2..16 ASCII digit converter.
//
// Converts the low NUMBER_WIDTH bits of an unsigned number into upper-case
// ASCII digits ('0'-'9', 'A'-'F') in a base from 2 to 16, most significant
// digit first, with last set on the final character; zero gives a single '0'.
// Bases 0 and 1 are treated as 2, bases 17..31 as 16. One number is worked on
// at a time: after the accept cycle each digit is computed in the restoring
// divider, which retires four dividend bits per cycle, and then the characters
// leave one at a time through the output register, holding while the output
// stalls. The last character sits in an output register, so the next number
// is accepted while it waits.
module integer_to_radix_ascii
    import itoa_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_item,
    output logic      chr_valid,
    input  logic      chr_stall,
    output chr_item_t chr_item
);

    itoa_cmd_t    cmd;
    itoa_status_t status;

    itoa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    itoa_dpath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .status    (status),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_item  (chr_item)
    );

endmodule

### rtl/core/itoa_ctrl.sv
// Controller state machine: accept a number, run digit divisions, emit characters.
module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  itoa_status_t status,
    output itoa_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a new transaction only between numbers
    assign req_stall = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_done && status.quot_zero)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.last_digit)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/core/itoa_dpath.sv
// Datapath: multi-bit restoring divider, digit stack and output register.
module itoa_dpath
    import itoa_pkg::*;
#(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  req_item_t    req_item,
    input  itoa_cmd_t    cmd,
    output itoa_status_t status,
    output logic         chr_valid,
    input  logic         chr_stall,
    output chr_item_t    chr_item
);

    localparam int PW     = ((NUMBER_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int STEPS  = PW / BITS_PER_STEP;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int DEPTH  = NUMBER_WIDTH;
    localparam int DCNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W  = (NUMBER_WIDTH > NUMBER_FIELD_W) ? NUMBER_WIDTH : NUMBER_FIELD_W;

    logic [PW-1:0]            work_reg;
    logic [DIGIT_W-1:0]       rem_reg;
    logic [RADIX_FIELD_W-1:0] radix_reg;
    logic [CNT_W-1:0]         step_cnt_reg;
    logic [DIGIT_W-1:0]       stack_reg [DEPTH];
    logic [DCNT_W-1:0]        count_reg;
    logic                     out_valid_reg;
    chr_item_t                out_item_reg;

    logic [EXT_W-1:0]         number_ext;
    logic [NUMBER_WIDTH-1:0]  number_used;
    logic [RADIX_FIELD_W-1:0] radix_clamped;
    logic [PW-1:0]            dv_work;
    logic [DIGIT_W-1:0]       dv_rem;
    logic                     last_step;
    logic                     push;

    // Keep the low bits of the number and clamp the base into 2..16
    assign number_ext  = EXT_W'(req_item.number);
    assign number_used = number_ext[NUMBER_WIDTH-1:0];

    always_comb
    begin
        if (req_item.radix < RADIX_MIN)
            radix_clamped = RADIX_MIN;
        else if (req_item.radix > RADIX_MAX)
            radix_clamped = RADIX_MAX;
        else
            radix_clamped = req_item.radix;
    end

    // Retire BITS_PER_STEP dividend bits per cycle; quotient bits shift in at the bottom
    always_comb
    begin
        logic [RADIX_FIELD_W-1:0] trial;
        dv_work = work_reg;
        dv_rem  = rem_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial   = {dv_rem, dv_work[PW-1]};
            dv_work = {dv_work[PW-2:0], 1'b0};
            if (trial >= radix_reg)
            begin
                trial      = trial - radix_reg;
                dv_work[0] = 1'b1;
            end
            dv_rem = trial[DIGIT_W-1:0];
        end
    end

    assign last_step = (step_cnt_reg == CNT_W'(STEPS - 1));
    assign push      = cmd.step && last_step;

    // Status back to the controller
    assign status.div_done   = last_step;
    assign status.quot_zero  = (dv_work == '0);
    assign status.out_free   = !out_valid_reg || !chr_stall;
    assign status.last_digit = (count_reg == DCNT_W'(1));

    // Divider registers: start on load, restart on the quotient after each digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.load || push)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            step_cnt_reg <= step_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_reg  <= PW'(number_used);
            rem_reg   <= '0;
            radix_reg <= radix_clamped;
        end
        else if (cmd.step)
        begin
            work_reg <= dv_work;
            rem_reg  <= push ? '0 : dv_rem;
        end
    end

    // Digit stack: push least significant first, pop most significant first
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_reg[0] <= dv_rem;
            for (int i = 1; i < DEPTH; i++)
                stack_reg[i] <= stack_reg[i-1];
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
                stack_reg[i] <= stack_reg[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load)
            count_reg <= '0;
        else if (push)
            count_reg <= count_reg + DCNT_W'(1);
        else if (cmd.pop)
            count_reg <= count_reg - DCNT_W'(1);
    end

    // Output register: load on pop, drop valid once the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.pop)
            out_valid_reg <= 1'b1;
        else if (!chr_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            out_item_reg.character <= digit_glyph(stack_reg[0]);
            out_item_reg.last      <= (count_reg == DCNT_W'(1));
        end
    end

    assign chr_valid = out_valid_reg;
    assign chr_item  = out_item_reg;

endmodule

### tb/tb_integer_to_radix_ascii.sv
// Self-checking testbench for the integer to radix ASCII digit converter.
module tb_integer_to_radix_ascii;
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 120;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_WAIT       = 13;

    // Digit glyphs, '0' in the top byte down to 'F' in the bottom byte
    localparam logic [127:0] GLYPHS = "0123456789ABCDEF";

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item = '0;
    logic      chr_valid;
    logic      chr_stall = 1'b0;
    chr_item_t chr_item;

    req_item_t pending_numbers[$];
    chr_item_t expected_chars[$];
    int        numbers_total = 0;
    int        numbers_taken = 0;
    int        mismatch_count = 0;
    int        idle_cycles = 0;

    logic      req_taken = 1'b0;
    logic      chr_taken = 1'b0;
    int        req_wait = 0;
    int        chr_hold = 0;
    int        req_quiet = 0;
    int        chr_quiet = 0;

    integer_to_radix_ascii DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_item  (chr_item)
    );

    always #5 clk = ~clk;

    // Draw the idle cycles for one transaction; a quiet stretch forces zero
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Queue the characters one number should produce, most significant first
    function automatic void predict_digits(req_item_t req);
        logic [4:0]  base;
        logic [15:0] value;
        logic [3:0]  digits[$];
        chr_item_t   chr;
        base  = (req.radix < 5'd2) ? 5'd2 : (req.radix > 5'd16) ? 5'd16 : req.radix;
        value = req.number;
        do
        begin
            digits.push_front(4'(value % base));
            value = value / base;
        end
        while (value != 16'd0);
        for (int k = 0; k < digits.size(); k++)
        begin
            chr.character = 7'(GLYPHS[8 * (15 - digits[k]) +: 8]);
            chr.last      = (k == digits.size() - 1);
            expected_chars.push_back(chr);
        end
    endfunction

    // Pick a number that spans short, long and all-ones digit strings
    function automatic logic [15:0] pick_number();
        unique case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 255));
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'(1 << $urandom_range(0, 15));
            default: return 16'($urandom >> $urandom_range(16, 31));
        endcase
    endfunction

    function automatic void add_number(logic [15:0] number, logic [4:0] radix);
        req_item_t req;
        req.number = number;
        req.radix  = radix;
        pending_numbers.push_back(req);
        numbers_total++;
    endfunction

    // Sender: present the next number once the current transaction is gone
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_taken))
        begin
            if (req_wait > 0)
            begin
                req_wait  <= req_wait - 1;
                req_valid <= 1'b0;
            end
            else if (pending_numbers.size() > 0)
            begin
                req_item  <= pending_numbers.pop_front();
                req_valid <= 1'b1;
                req_wait  <= draw_wait(req_quiet);
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: hold stall for a drawn number of cycles after each transaction
    always @(negedge clk)
    begin : chr_side
        int hold;
        if (rst_n)
        begin
            hold = chr_taken ? draw_wait(chr_quiet) : chr_hold;
            if (hold > 0)
            begin
                chr_stall <= 1'b1;
                chr_hold  <= hold - 1;
            end
            else
            begin
                chr_stall <= 1'b0;
                chr_hold  <= 0;
            end
        end
    end

    // Check each character against the oldest expectation, then predict
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        chr_taken <= rst_n && chr_valid && !chr_stall;
        if (rst_n && chr_valid && !chr_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected character 0x%02h last %0b",
                             chr_item.character, chr_item.last);
            end
            else
            begin : compare
                chr_item_t want;
                want = expected_chars.pop_front();
                if (chr_item.character !== want.character ||
                    chr_item.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"character mismatch: expected 0x%02h last %0b,",
                                  " got 0x%02h last %0b"},
                                 want.character, want.last,
                                 chr_item.character, chr_item.last);
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            predict_digits(req_item);
            numbers_taken++;
        end
    end

    // Abort when neither channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (chr_valid && !chr_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("FAIL integer_to_radix_ascii");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [4:0] radix;

        // Directed: radix codes 0 to 17 and 31, including clamped ones
        for (int r = 0; r <= 17; r++)
            add_number(16'($urandom), 5'(r));
        add_number(16'($urandom), 5'd31);
        // Directed: zero, all ones and a few short strings
        add_number(16'd0, 5'd10);
        add_number(16'd0, 5'd2);
        add_number(16'hFFFF, 5'd2);
        add_number(16'hFFFF, 5'd16);
        add_number(16'hFFFF, 5'd3);
        add_number(16'd1, 5'd16);

        // Random: mostly legal bases, some out-of-range codes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            radix = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(2, 16));
            add_number(pick_number(), radix);
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        wait (numbers_taken == numbers_total);
        wait (expected_chars.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS integer_to_radix_ascii");
        else
            $display("FAIL integer_to_radix_ascii");
        $finish;
    end

endmodule

### filelist.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_ctrl.sv
rtl/core/itoa_dpath.sv
rtl/core/integer_to_radix_ascii.sv
tb/tb_integer_to_radix_ascii.sv
